FILE: hdl/iedq_pkg.sv
//------------------------------------------------------------------------------
// iedq_pkg: shared types and constants of the input edge queue
// Edge and key records, request/response records, op and status codes.
//------------------------------------------------------------------------------
`default_nettype none

package iedq_pkg;

	localparam int EDGE_DEPTH_DEF = 32;
	localparam int HELD_DEPTH_DEF = 64;
	localparam logic [15:0] WINDOW_RST = 16'd80;
	localparam logic [1:0] KBD_KIND_RST = 2'd0;

	// request ops
	localparam logic [1:0] OP_PUSH  = 2'd0;
	localparam logic [1:0] OP_DRAIN = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// result status codes
	localparam logic [2:0] ST_QUEUED    = 3'd0;
	localparam logic [2:0] ST_REDUNDANT = 3'd1;
	localparam logic [2:0] ST_DEBOUNCED = 3'd2;
	localparam logic [2:0] ST_HELD_FULL = 3'd3;
	localparam logic [2:0] ST_DISABLED  = 3'd4;
	localparam logic [2:0] ST_DRAIN     = 3'd5;

	// configuration register indexes
	localparam logic [1:0] CFG_ENABLE = 2'd0;
	localparam logic [1:0] CFG_WINDOW = 2'd1;
	localparam logic [1:0] CFG_KBD    = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DRAIN
	} state_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  pad;
		logic [19:0] payload;
		logic        pressed;
		logic [15:0] vendor;
		logic [15:0] product;
	} edge_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  pad;
		logic [19:0] payload;
		logic [15:0] vendor;
		logic [15:0] product;
	} key_t;

	typedef struct packed {
		logic [1:0]  op;
		edge_t       ev;
		logic [31:0] time_ms;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic       edge_valid;
		edge_t      ev;
		logic       last;
	} rsp_t;

	typedef struct packed {
		logic ins;
		logic del;
	} held_ctl_t;

	typedef struct packed {
		logic load;
		logic shift;
	} edge_ctl_t;

endpackage

`default_nettype wire

FILE: hdl/iedq_req_if.sv
//------------------------------------------------------------------------------
// iedq_req_if: request channel of the input edge queue
// Valid/ready handshake with the request fields.
//------------------------------------------------------------------------------
`default_nettype none

interface iedq_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [1:0]  source_kind;
	logic [3:0]  pad_index;
	logic [19:0] payload;
	logic        pressed;
	logic [15:0] vendor_id;
	logic [15:0] product_id;
	logic [31:0] time_ms;

	modport source (
		output valid, op, source_kind, pad_index, payload, pressed,
		       vendor_id, product_id, time_ms,
		input  ready
	);
	modport sink (
		input  valid, op, source_kind, pad_index, payload, pressed,
		       vendor_id, product_id, time_ms,
		output ready
	);
endinterface

`default_nettype wire

FILE: hdl/iedq_rsp_if.sv
//------------------------------------------------------------------------------
// iedq_rsp_if: response channel of the input edge queue
// Valid/ready handshake with the result fields.
//------------------------------------------------------------------------------
`default_nettype none

interface iedq_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic        edge_valid;
	logic [1:0]  out_kind;
	logic [3:0]  out_pad;
	logic [19:0] out_payload;
	logic        out_pressed;
	logic [15:0] out_vendor;
	logic [15:0] out_product;
	logic        last;

	modport source (
		output valid, status, edge_valid, out_kind, out_pad, out_payload,
		       out_pressed, out_vendor, out_product, last,
		input  ready
	);
	modport sink (
		input  valid, status, edge_valid, out_kind, out_pad, out_payload,
		       out_pressed, out_vendor, out_product, last,
		output ready
	);
endinterface

`default_nettype wire

FILE: hdl/input_edge_queue_core.sv
//------------------------------------------------------------------------------
// input_edge_queue_core: press/release edge queue with debounce and held store
// A push is accepted, then matched against every cell of the held chain and
// checked against the debounce record. A drain shifts its edges out of cell
// 0 of the edge chain, one edge per cycle while the response side takes them.
// Clear and the unused op are finished when accepted. Results sit in an output
// register, so a new request is accepted while the last result is waiting.
// No clearing pass after reset; both chains are tracked by fill counts.
//------------------------------------------------------------------------------
`default_nettype none

module input_edge_queue_core #(
	parameter int EDGE_DEPTH = iedq_pkg::EDGE_DEPTH_DEF,
	parameter int HELD_DEPTH = iedq_pkg::HELD_DEPTH_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cfg_we,
	input  wire [1:0]         cfg_idx,
	input  wire [15:0]        cfg_data,
	iedq_req_if.sink          req,
	iedq_rsp_if.source        rsp
);

	localparam int ECW = $clog2(EDGE_DEPTH + 1);
	localparam int HCW = $clog2(HELD_DEPTH + 1);

	iedq_pkg::state_t state_q, state_d;

	logic        enable_q;
	logic [15:0] window_q;
	logic [1:0]  kbd_q;

	logic [31:0] lp_time_q;
	logic [7:0]  lp_code_q;
	logic [31:0] lp_dev_q;

	logic [ECW-1:0] e_count_q;
	logic [HCW-1:0] h_count_q;

	iedq_pkg::req_t rq_q;
	iedq_pkg::rsp_t rsp_q, rsp_d;
	logic           rsp_valid_q;
	logic           rsp_load;
	logic           out_free;

	logic req_fire, clr;
	logic push_commit, drain_step;

	iedq_pkg::held_ctl_t h_ctl;
	iedq_pkg::edge_ctl_t e_ctl;
	iedq_pkg::key_t      probe;
	iedq_pkg::key_t      hkey [HELD_DEPTH];
	iedq_pkg::edge_t     ecell [EDGE_DEPTH];
	logic [HELD_DEPTH-1:0] hit, sh;

	logic        kbd_press, bounce, found, h_full, e_full, ins_ok;
	logic [31:0] dt;
	logic [31:0] dev;
	logic [2:0]  push_status;

	assign req_fire = req.valid && req.ready;
	assign req.ready = (state_q == iedq_pkg::S_IDLE);
	assign clr = req_fire && (req.op == iedq_pkg::OP_CLEAR);
	assign out_free = !rsp_valid_q || rsp.ready;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			window_q <= iedq_pkg::WINDOW_RST;
			kbd_q    <= iedq_pkg::KBD_KIND_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				iedq_pkg::CFG_ENABLE: enable_q <= cfg_data[0];
				iedq_pkg::CFG_WINDOW: window_q <= cfg_data;
				iedq_pkg::CFG_KBD:    kbd_q    <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// request register
	always_ff @(posedge clk) begin
		if (req_fire) begin
			rq_q.op         <= req.op;
			rq_q.ev.kind    <= req.source_kind;
			rq_q.ev.pad     <= req.pad_index;
			rq_q.ev.payload <= req.payload;
			rq_q.ev.pressed <= req.pressed;
			rq_q.ev.vendor  <= req.vendor_id;
			rq_q.ev.product <= req.product_id;
			rq_q.time_ms    <= req.time_ms;
		end
	end

	assign probe = '{kind: rq_q.ev.kind, pad: rq_q.ev.pad, payload: rq_q.ev.payload,
		vendor: rq_q.ev.vendor, product: rq_q.ev.product};

	// held-key chain
	assign sh[0] = hit[0];
	for (genvar i = 1; i < HELD_DEPTH; i++) begin : g_sh
		assign sh[i] = sh[i-1] | hit[i];
	end

	for (genvar i = 0; i < HELD_DEPTH; i++) begin : g_held
		iedq_pkg::key_t nk;
		if (i == HELD_DEPTH - 1) begin : g_top
			assign nk = '0;
		end else begin : g_mid
			assign nk = hkey[i+1];
		end
		iedq_held_cell u_cell (
			.clk      (clk),
			.ctl      (h_ctl),
			.here     (h_count_q == HCW'(i)),
			.shift    (sh[i]),
			.valid    (HCW'(i) < h_count_q),
			.probe    (probe),
			.next_key (nk),
			.key      (hkey[i]),
			.hit      (hit[i])
		);
	end

	// edge chain
	for (genvar i = 0; i < EDGE_DEPTH; i++) begin : g_edge
		iedq_pkg::edge_t ne;
		logic            here;
		if (i == EDGE_DEPTH - 1) begin : g_top
			assign ne = '0;
			assign here = e_full || (e_count_q == ECW'(i));
		end else begin : g_mid
			assign ne = ecell[i+1];
			assign here = !e_full && (e_count_q == ECW'(i));
		end
		iedq_edge_cell u_cell (
			.clk       (clk),
			.ctl       (e_ctl),
			.here      (here),
			.din       (rq_q.ev),
			.next_edge (ne),
			.dout      (ecell[i])
		);
	end

	// push decision
	always_comb begin
		dev       = {rq_q.ev.vendor, rq_q.ev.product};
		dt        = rq_q.time_ms - lp_time_q;
		kbd_press = rq_q.ev.pressed && (rq_q.ev.kind == kbd_q);
		bounce    = kbd_press && (lp_time_q != 32'd0) && (rq_q.time_ms >= lp_time_q)
			&& (dt < {16'd0, window_q}) && (lp_code_q == rq_q.ev.payload[7:0])
			&& (lp_dev_q != 32'd0) && (dev != lp_dev_q);
		found  = |hit;
		h_full = (h_count_q == HCW'(HELD_DEPTH));
		e_full = (e_count_q == ECW'(EDGE_DEPTH));
		ins_ok = 1'b0;
		if (bounce) begin
			push_status = iedq_pkg::ST_DEBOUNCED;
		end else if (rq_q.ev.pressed) begin
			if (found) begin
				push_status = iedq_pkg::ST_REDUNDANT;
			end else if (h_full) begin
				push_status = iedq_pkg::ST_HELD_FULL;
			end else begin
				push_status = iedq_pkg::ST_QUEUED;
				ins_ok = 1'b1;
			end
		end else begin
			push_status = found ? iedq_pkg::ST_QUEUED : iedq_pkg::ST_REDUNDANT;
		end
	end

	assign h_ctl.ins   = push_commit && ins_ok;
	assign h_ctl.del   = push_commit && !rq_q.ev.pressed && !bounce && found;
	assign e_ctl.load  = push_commit && (push_status == iedq_pkg::ST_QUEUED);
	assign e_ctl.shift = drain_step || (e_ctl.load && e_full);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			iedq_pkg::S_IDLE: begin
				if (req_fire && (req.op == iedq_pkg::OP_PUSH || req.op == iedq_pkg::OP_DRAIN))
					state_d = iedq_pkg::S_EXEC;
			end
			iedq_pkg::S_EXEC: begin
				if (out_free) begin
					if (enable_q && rq_q.op == iedq_pkg::OP_DRAIN && e_count_q != '0)
						state_d = iedq_pkg::S_DRAIN;
					else
						state_d = iedq_pkg::S_IDLE;
				end
			end
			iedq_pkg::S_DRAIN: begin
				if (out_free && e_count_q == ECW'(1))
					state_d = iedq_pkg::S_IDLE;
			end
			default: state_d = iedq_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		rsp_load    = 1'b0;
		rsp_d       = '0;
		push_commit = 1'b0;
		drain_step  = 1'b0;
		case (state_q)
			iedq_pkg::S_EXEC: begin
				if (out_free) begin
					if (!enable_q) begin
						rsp_load     = 1'b1;
						rsp_d.status = iedq_pkg::ST_DISABLED;
						rsp_d.last   = 1'b1;
					end else if (rq_q.op == iedq_pkg::OP_PUSH) begin
						rsp_load     = 1'b1;
						push_commit  = 1'b1;
						rsp_d.status = push_status;
						rsp_d.last   = 1'b1;
					end else if (e_count_q == '0) begin
						rsp_load     = 1'b1;
						rsp_d.status = iedq_pkg::ST_DRAIN;
						rsp_d.last   = 1'b1;
					end
				end
			end
			iedq_pkg::S_DRAIN: begin
				if (out_free) begin
					rsp_load         = 1'b1;
					drain_step       = 1'b1;
					rsp_d.status     = iedq_pkg::ST_DRAIN;
					rsp_d.edge_valid = 1'b1;
					rsp_d.ev         = ecell[0];
					rsp_d.last       = (e_count_q == ECW'(1));
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= iedq_pkg::S_IDLE;
			rsp_valid_q <= 1'b0;
			e_count_q   <= '0;
			h_count_q   <= '0;
			lp_time_q   <= '0;
			lp_code_q   <= '0;
			lp_dev_q    <= '0;
		end else begin
			state_q <= state_d;
			if (rsp_load)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;

			if (clr)
				e_count_q <= '0;
			else if (e_ctl.load && !e_full)
				e_count_q <= e_count_q + ECW'(1);
			else if (drain_step)
				e_count_q <= e_count_q - ECW'(1);

			if (clr)
				h_count_q <= '0;
			else if (h_ctl.ins)
				h_count_q <= h_count_q + HCW'(1);
			else if (h_ctl.del)
				h_count_q <= h_count_q - HCW'(1);

			if (clr) begin
				lp_time_q <= '0;
				lp_code_q <= '0;
				lp_dev_q  <= '0;
			end else if (push_commit && kbd_press && !bounce) begin
				lp_time_q <= rq_q.time_ms;
				lp_code_q <= rq_q.ev.payload[7:0];
				lp_dev_q  <= dev;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load)
			rsp_q <= rsp_d;
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_q.status;
	assign rsp.edge_valid  = rsp_q.edge_valid;
	assign rsp.out_kind    = rsp_q.ev.kind;
	assign rsp.out_pad     = rsp_q.ev.pad;
	assign rsp.out_payload = rsp_q.ev.payload;
	assign rsp.out_pressed = rsp_q.ev.pressed;
	assign rsp.out_vendor  = rsp_q.ev.vendor;
	assign rsp.out_product = rsp_q.ev.product;
	assign rsp.last        = rsp_q.last;

`ifndef NO_ASSERTIONS
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		h_count_q <= HCW'(HELD_DEPTH))
		else $error("held count beyond depth");

	a_edge_bound: assert property (@(posedge clk) disable iff (!arst_n)
		e_count_q <= ECW'(EDGE_DEPTH))
		else $error("edge count beyond depth");

	a_key_unique: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit))
		else $error("key held in more than one cell");

	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == iedq_pkg::S_DRAIN |-> e_count_q != '0)
		else $error("drain with empty queue");

	a_drain_end: assert property (@(posedge clk) disable iff (!arst_n)
		drain_step && e_count_q == ECW'(1) |=> e_count_q == '0 && state_q == iedq_pkg::S_IDLE)
		else $error("drain did not finish empty");
`endif

endmodule

`default_nettype wire

FILE: hdl/iedq_held_cell.sv
//------------------------------------------------------------------------------
// iedq_held_cell: one entry of the held-key chain
// Holds one key, compares it with the probe, takes the probe on insert and
// its upper neighbor's key when an entry at or below it is removed.
//------------------------------------------------------------------------------
`default_nettype none

module iedq_held_cell (
	input  wire                 clk,
	input  iedq_pkg::held_ctl_t ctl,
	input  wire                 here,
	input  wire                 shift,
	input  wire                 valid,
	input  iedq_pkg::key_t      probe,
	input  iedq_pkg::key_t      next_key,
	output iedq_pkg::key_t      key,
	output logic                hit
);

	iedq_pkg::key_t key_q;

	always_ff @(posedge clk) begin
		if (ctl.ins && here) begin
			key_q <= probe;
		end else if (ctl.del && shift) begin
			key_q <= next_key;
		end
	end

	assign key = key_q;
	assign hit = valid && (key_q == probe);

endmodule

`default_nettype wire

FILE: hdl/iedq_edge_cell.sv
//------------------------------------------------------------------------------
// iedq_edge_cell: one slot of the edge queue chain
// Cell 0 holds the oldest edge; a shift moves every edge one cell down.
//------------------------------------------------------------------------------
`default_nettype none

module iedq_edge_cell (
	input  wire                 clk,
	input  iedq_pkg::edge_ctl_t ctl,
	input  wire                 here,
	input  iedq_pkg::edge_t     din,
	input  iedq_pkg::edge_t     next_edge,
	output iedq_pkg::edge_t     dout
);

	iedq_pkg::edge_t edge_q;

	always_ff @(posedge clk) begin
		if (ctl.load && here) begin
			edge_q <= din;
		end else if (ctl.shift) begin
			edge_q <= next_edge;
		end
	end

	assign dout = edge_q;

endmodule

`default_nettype wire

FILE: verif/input_edge_queue_core_tb.sv
//------------------------------------------------------------------------------
// input_edge_queue_core_tb: self-checking bench for the input edge queue
// Sends push, drain, clear and unused requests: first a short directed table,
// then random phases with realistic press/release traffic, a held-store
// overflow run and a long response hold-off. Every response is compared field
// by field to a fixed status or the bench model of debounce, held store, ring.
//------------------------------------------------------------------------------
`default_nettype none

module input_edge_queue_core_tb;
	import iedq_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES = 40;

	typedef struct {
		bit          set_regs;
		bit          en;
		logic [15:0] win;
		logic [1:0]  kbd;
		req_t        rq;
		bit          fixed;
		logic [2:0]  fixed_st;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_idx;
	logic [15:0] cfg_data;

	iedq_req_if req_ch();
	iedq_rsp_if rsp_ch();

	input_edge_queue_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always #6 clk = ~clk;

	// model state
	bit          c_enable;
	logic [15:0] c_window;
	logic [1:0]  c_kbd;
	edge_t       ring_q[$];
	bit          held_ok [HELD_DEPTH_DEF];
	key_t        held_key [HELD_DEPTH_DEF];
	logic [31:0] kb_time;
	logic [7:0]  kb_code;
	logic [31:0] kb_dev;

	rsp_t        step_out[$];
	rsp_t        owed[$];
	plan_row_t   plan[$];

	int          idle_pct;
	int          stall_pct;
	bit          hold_req;
	logic [31:0] tick;
	logic [3:0]  pad_pool [3];
	logic [19:0] code_pool [6];
	logic [31:0] dev_pool [4];

	int          errors;
	int          checked;
	int          n_req;
	int          seen_status [8];

	function automatic void wipe_model();
		ring_q.delete();
		foreach (held_ok[i]) held_ok[i] = 1'b0;
		kb_time = '0;
		kb_code = '0;
		kb_dev = '0;
	endfunction

	function automatic void compute_edge_results(input req_t r);
		rsp_t        o;
		key_t        k;
		logic [2:0]  st;
		logic [31:0] dev;
		int          hit;
		int          slot;
		step_out.delete();
		o = '0;
		o.last = 1'b1;
		hit = -1;
		slot = -1;
		if (r.op == OP_CLEAR) begin
			wipe_model();
		end else if (r.op == OP_UNUSED) begin
		end else if (!c_enable) begin
			o.status = ST_DISABLED;
			step_out = {step_out, o};
		end else if (r.op == OP_DRAIN) begin
			o.status = ST_DRAIN;
			if (ring_q.size() == 0) begin
				step_out = {step_out, o};
			end else begin
				foreach (ring_q[i]) begin
					o.edge_valid = 1'b1;
					o.ev = ring_q[i];
					o.last = (i == ring_q.size() - 1);
					step_out = {step_out, o};
				end
				ring_q.delete();
			end
		end else begin
			st = ST_QUEUED;
			dev = {r.ev.vendor, r.ev.product};
			if (r.ev.pressed && r.ev.kind == c_kbd) begin
				if (kb_time != 0 && r.time_ms >= kb_time &&
				    (r.time_ms - kb_time) < {16'd0, c_window} &&
				    kb_code == r.ev.payload[7:0] && kb_dev != 0 && dev != kb_dev) begin
					st = ST_DEBOUNCED;
				end else begin
					kb_time = r.time_ms;
					kb_code = r.ev.payload[7:0];
					kb_dev = dev;
				end
			end
			if (st == ST_QUEUED) begin
				k = {r.ev.kind, r.ev.pad, r.ev.payload, r.ev.vendor, r.ev.product};
				for (int i = 0; i < HELD_DEPTH_DEF; i++) begin
					if (held_ok[i]) begin
						if (held_key[i] == k) hit = i;
					end else if (slot < 0) begin
						slot = i;
					end
				end
				if (r.ev.pressed) begin
					if (hit >= 0) begin
						st = ST_REDUNDANT;
					end else if (slot < 0) begin
						st = ST_HELD_FULL;
					end else begin
						held_ok[slot] = 1'b1;
						held_key[slot] = k;
					end
				end else if (hit < 0) begin
					st = ST_REDUNDANT;
				end else begin
					held_ok[hit] = 1'b0;
				end
			end
			if (st == ST_QUEUED) begin
				if (ring_q.size() >= EDGE_DEPTH_DEF) void'(ring_q.pop_front());
				ring_q = {ring_q, r.ev};
			end
			o.status = st;
			step_out = {step_out, o};
		end
	endfunction

	function automatic plan_row_t step_row(input logic [1:0] op, input logic [1:0] kind,
			input logic [3:0] pad, input logic [19:0] payload, input logic pressed,
			input logic [15:0] vid, input logic [15:0] pid, input logic [31:0] t,
			input bit fixed, input logic [2:0] st);
		plan_row_t p;
		p = '{default: '0};
		p.rq.op = op;
		p.rq.ev = {kind, pad, payload, pressed, vid, pid};
		p.rq.time_ms = t;
		p.fixed = fixed;
		p.fixed_st = st;
		return p;
	endfunction

	function automatic plan_row_t regs_row(input bit en, input logic [15:0] win,
			input logic [1:0] kbd);
		plan_row_t p;
		p = '{default: '0};
		p.set_regs = 1'b1;
		p.en = en;
		p.win = win;
		p.kbd = kbd;
		return p;
	endfunction

	function automatic void add_row(input plan_row_t p);
		plan = {plan, p};
	endfunction

	function automatic req_t draw_request();
		req_t        r;
		key_t        k;
		logic [31:0] dev;
		int          held_at[$];
		int          pick;
		r = '0;
		pick = $urandom_range(99);
		if (pick < 6) r.op = OP_DRAIN;
		else if (pick < 8) r.op = OP_CLEAR;
		else if (pick < 10) r.op = OP_UNUSED;
		else r.op = OP_PUSH;
		if ($urandom_range(49) == 0) tick = $urandom;
		else tick = tick + $urandom_range(60);
		r.time_ms = tick;
		for (int i = 0; i < HELD_DEPTH_DEF; i++)
			if (held_ok[i]) held_at = {held_at, i};
		if ($urandom_range(9) == 0) begin
			r.ev.kind = 2'($urandom_range(3));
			r.ev.pad = 4'($urandom_range(15));
			r.ev.payload = 20'($urandom_range(20'hFFFFF));
			r.ev.pressed = 1'($urandom_range(1));
			r.ev.vendor = 16'($urandom_range(16'hFFFF));
			r.ev.product = 16'($urandom_range(16'hFFFF));
		end else if (held_at.size() != 0 && $urandom_range(1) == 1) begin
			k = held_key[held_at[$urandom_range(held_at.size() - 1)]];
			r.ev = {k.kind, k.pad, k.payload, 1'b0, k.vendor, k.product};
		end else begin
			dev = dev_pool[$urandom_range(3)];
			r.ev.kind = 2'($urandom_range(3));
			r.ev.pad = pad_pool[$urandom_range(2)];
			r.ev.payload = code_pool[$urandom_range(5)];
			r.ev.pressed = ($urandom_range(9) != 0);
			r.ev.vendor = dev[31:16];
			r.ev.product = dev[15:0];
		end
		return r;
	endfunction

	function automatic string rsp_text(input rsp_t x);
		return $sformatf("st=%0d ev=%0d kind=%0d pad=%0d pl=%05h pr=%0d vid=%04h pid=%04h last=%0d",
			x.status, x.edge_valid, x.ev.kind, x.ev.pad, x.ev.payload, x.ev.pressed,
			x.ev.vendor, x.ev.product, x.last);
	endfunction

	task automatic send_item(input req_t r, input bit fixed, input logic [2:0] st);
		rsp_t f;
		while ($urandom_range(99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op <= r.op;
		req_ch.source_kind <= r.ev.kind;
		req_ch.pad_index <= r.ev.pad;
		req_ch.payload <= r.ev.payload;
		req_ch.pressed <= r.ev.pressed;
		req_ch.vendor_id <= r.ev.vendor;
		req_ch.product_id <= r.ev.product;
		req_ch.time_ms <= r.time_ms;
		do @(posedge clk); while (!req_ch.ready);
		n_req++;
		compute_edge_results(r);
		if (fixed) begin
			f = '0;
			f.status = st;
			f.last = 1'b1;
			owed = {owed, f};
		end else begin
			owed = {owed, step_out};
		end
	endtask

	task automatic settle();
		req_ch.valid <= 1'b0;
		while (owed.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_regs(input bit en, input logic [15:0] win, input logic [1:0] kbd);
		cfg_we <= 1'b1;
		cfg_idx <= CFG_ENABLE;
		cfg_data <= {15'd0, en};
		@(posedge clk);
		c_enable = en;
		cfg_idx <= CFG_WINDOW;
		cfg_data <= win;
		@(posedge clk);
		c_window = win;
		cfg_idx <= CFG_KBD;
		cfg_data <= {14'd0, kbd};
		@(posedge clk);
		c_kbd = kbd;
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(input int idle, input int stall, input int n, input bit en,
			input logic [15:0] win, input logic [1:0] kbd);
		settle();
		idle_pct = idle;
		stall_pct = stall;
		program_regs(en, win, kbd);
		repeat (n) send_item(draw_request(), 1'b0, ST_QUEUED);
	endtask

	initial begin : rsp_side
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				for (int n = 0; n < HOLD_CYCLES; n++) begin
					rsp_ch.ready <= 1'b0;
					@(posedge clk);
				end
			end
			rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin : result_check
		rsp_t got;
		rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.status = rsp_ch.status;
			got.edge_valid = rsp_ch.edge_valid;
			got.ev.kind = rsp_ch.out_kind;
			got.ev.pad = rsp_ch.out_pad;
			got.ev.payload = rsp_ch.out_payload;
			got.ev.pressed = rsp_ch.out_pressed;
			got.ev.vendor = rsp_ch.out_vendor;
			got.ev.product = rsp_ch.out_product;
			got.last = rsp_ch.last;
			seen_status[got.status]++;
			if (owed.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected response: %s", rsp_text(got));
			end else begin
				want = owed.pop_front();
				checked++;
				if (got.status !== want.status || got.edge_valid !== want.edge_valid ||
				    got.ev.kind !== want.ev.kind || got.ev.pad !== want.ev.pad ||
				    got.ev.payload !== want.ev.payload ||
				    got.ev.pressed !== want.ev.pressed ||
				    got.ev.vendor !== want.ev.vendor ||
				    got.ev.product !== want.ev.product || got.last !== want.last) begin
					errors++;
					if (errors <= 10) begin
						$display("mismatch at %0t", $realtime);
						$display("  exp %s", rsp_text(want));
						$display("  got %s", rsp_text(got));
					end
				end
			end
		end
	end

	initial begin : watchdog
		#4800000;
		$display("timeout with %0d responses outstanding", owed.size());
		$display("FAILED: results differ");
		$finish;
	end

	initial begin : stimulus
		req_t r;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= CFG_ENABLE;
		cfg_data <= '0;
		req_ch.valid <= 1'b0;
		req_ch.op <= OP_PUSH;
		req_ch.source_kind <= '0;
		req_ch.pad_index <= '0;
		req_ch.payload <= '0;
		req_ch.pressed <= 1'b0;
		req_ch.vendor_id <= '0;
		req_ch.product_id <= '0;
		req_ch.time_ms <= '0;
		c_enable = 1'b0;
		c_window = WINDOW_RST;
		c_kbd = KBD_KIND_RST;
		wipe_model();
		idle_pct = 0;
		stall_pct = 0;
		hold_req = 1'b0;
		tick = 32'd1;
		errors = 0;
		checked = 0;
		n_req = 0;
		foreach (seen_status[i]) seen_status[i] = 0;
		pad_pool = '{4'h0, 4'h9, 4'hF};
		foreach (code_pool[i])
			code_pool[i] = {12'($urandom_range(12'hFFF)), (i < 3) ? 8'h41 : 8'h42};
		dev_pool = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, $urandom};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: disabled block, debounce corners, held store, extremes
		add_row(step_row(OP_PUSH, 2'd0, 4'd0, 20'h00041, 1'b1, 16'h0001, 16'h0002,
			32'd100, 1'b1, ST_DISABLED));
		add_row(step_row(OP_DRAIN, 2'd0, 4'd0, 20'h0, 1'b0, 16'h0, 16'h0, 32'd0,
			1'b1, ST_DISABLED));
		add_row(step_row(OP_UNUSED, 2'd3, 4'd15, 20'hFFFFF, 1'b1, 16'hFFFF, 16'hFFFF,
			32'hFFFF_FFFF, 1'b0, ST_QUEUED));
		add_row(step_row(OP_CLEAR, 2'd0, 4'd0, 20'h0, 1'b0, 16'h0, 16'h0, 32'd0,
			1'b0, ST_QUEUED));
		add_row(regs_row(1'b1, WINDOW_RST, KBD_KIND_RST));
		add_row(step_row(OP_DRAIN, 2'd0, 4'd0, 20'h0, 1'b0, 16'h0, 16'h0, 32'd0,
			1'b1, ST_DRAIN));
		add_row(step_row(OP_PUSH, 2'd0, 4'd0, 20'h00041, 1'b1, 16'h0001, 16'h0002,
			32'd100, 1'b1, ST_QUEUED));
		add_row(step_row(OP_PUSH, 2'd0, 4'd1, 20'h00041, 1'b1, 16'h0003, 16'h0004,
			32'd150, 1'b0, ST_QUEUED));
		add_row(step_row(OP_PUSH, 2'd0, 4'd0, 20'h00041, 1'b1, 16'h0001, 16'h0002,
			32'd160, 1'b0, ST_QUEUED));
		add_row(step_row(OP_PUSH, 2'd0, 4'd0, 20'h00041, 1'b0, 16'h0001, 16'h0002,
			32'd170, 1'b0, ST_QUEUED));
		add_row(step_row(OP_PUSH, 2'd0, 4'd0, 20'h00041, 1'b0, 16'h0001, 16'h0002,
			32'd180, 1'b0, ST_QUEUED));
		add_row(step_row(OP_PUSH, 2'd3, 4'd15, 20'hFFFFF, 1'b1, 16'hFFFF, 16'hFFFF,
			32'hFFFF_FFFF, 1'b0, ST_QUEUED));
		add_row(step_row(OP_PUSH, 2'd0, 4'd0, 20'h00000, 1'b1, 16'h0000, 16'h0000,
			32'd0, 1'b0, ST_QUEUED));
		add_row(step_row(OP_PUSH, 2'd0, 4'd0, 20'h00100, 1'b1, 16'h0005, 16'h0006,
			32'd5, 1'b0, ST_QUEUED));
		add_row(step_row(OP_PUSH, 2'd0, 4'd0, 20'h00200, 1'b1, 16'h0007, 16'h0008,
			32'd10, 1'b0, ST_QUEUED));
		add_row(step_row(OP_PUSH, 2'd1, 4'd2, 20'h12345, 1'b0, 16'h0009, 16'h0009,
			32'd20, 1'b0, ST_QUEUED));
		add_row(step_row(OP_DRAIN, 2'd0, 4'd0, 20'h0, 1'b0, 16'h0, 16'h0, 32'd30,
			1'b0, ST_QUEUED));
		add_row(regs_row(1'b1, 16'd0, KBD_KIND_RST));
		add_row(step_row(OP_PUSH, 2'd0, 4'd3, 20'h00077, 1'b1, 16'hAAAA, 16'h5555,
			32'd2000, 1'b0, ST_QUEUED));
		add_row(step_row(OP_PUSH, 2'd0, 4'd4, 20'h00077, 1'b1, 16'h5555, 16'hAAAA,
			32'd2000, 1'b0, ST_QUEUED));
		add_row(regs_row(1'b1, 16'hFFFF, 2'd3));
		add_row(step_row(OP_PUSH, 2'd3, 4'd0, 20'h00077, 1'b1, 16'h0001, 16'h0001,
			32'd3000, 1'b0, ST_QUEUED));
		add_row(step_row(OP_PUSH, 2'd3, 4'd0, 20'h00077, 1'b1, 16'h0002, 16'h0002,
			32'd68534, 1'b0, ST_QUEUED));
		add_row(step_row(OP_PUSH, 2'd3, 4'd0, 20'h00077, 1'b1, 16'h0002, 16'h0002,
			32'd68535, 1'b0, ST_QUEUED));
		add_row(step_row(OP_DRAIN, 2'd0, 4'd0, 20'h0, 1'b0, 16'h0, 16'h0, 32'd0,
			1'b0, ST_QUEUED));
		add_row(step_row(OP_CLEAR, 2'd0, 4'd0, 20'h0, 1'b0, 16'h0, 16'h0, 32'd0,
			1'b0, ST_QUEUED));
		add_row(step_row(OP_DRAIN, 2'd0, 4'd0, 20'h0, 1'b0, 16'h0, 16'h0, 32'd0,
			1'b1, ST_DRAIN));

		foreach (plan[i]) begin
			if (plan[i].set_regs) begin
				settle();
				program_regs(plan[i].en, plan[i].win, plan[i].kbd);
			end else begin
				send_item(plan[i].rq, plan[i].fixed, plan[i].fixed_st);
			end
		end

		// fill the held store past capacity; ring wraps on the way
		settle();
		idle_pct = 0;
		stall_pct = 0;
		program_regs(1'b1, WINDOW_RST, 2'd0);
		r = '0;
		r.op = OP_CLEAR;
		send_item(r, 1'b0, ST_QUEUED);
		for (int i = 0; i < HELD_DEPTH_DEF + 6; i++) begin
			r = '0;
			r.op = OP_PUSH;
			r.ev = {2'd1, 4'(i), 20'(i * 977), 1'b1, 16'h00AB, 16'h00CD};
			tick = tick + 1;
			r.time_ms = tick;
			send_item(r, 1'b0, ST_QUEUED);
		end
		r = '0;
		r.op = OP_DRAIN;
		send_item(r, 1'b0, ST_QUEUED);

		// response side holds off while requests keep coming
		hold_req = 1'b1;
		repeat (40) send_item(draw_request(), 1'b0, ST_QUEUED);

		run_phase(0, 0, 90, 1'b1, WINDOW_RST, 2'd0);
		run_phase(58, 0, 90, 1'b1, 16'd0, 2'd1);
		run_phase(0, 58, 90, 1'b1, 16'hFFFF, 2'd2);
		run_phase(35, 35, 90, 1'b1, 16'($urandom_range(300)), 2'd3);
		run_phase(35, 35, 15, 1'b0, 16'($urandom_range(16'hFFFF)), 2'($urandom_range(3)));

		req_ch.valid <= 1'b0;
		while (owed.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("run covered %0d requests over five idle/stall mixes, %0d responses checked",
			n_req, checked);
		$display("statuses seen: queued %0d redundant %0d debounced %0d full %0d off %0d drain %0d",
			seen_status[ST_QUEUED], seen_status[ST_REDUNDANT], seen_status[ST_DEBOUNCED],
			seen_status[ST_HELD_FULL], seen_status[ST_DISABLED], seen_status[ST_DRAIN]);
		if (errors == 0 && owed.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

`default_nettype wire

FILE: filelist.f
hdl/iedq_pkg.sv
hdl/iedq_req_if.sv
hdl/iedq_rsp_if.sv
hdl/iedq_held_cell.sv
hdl/iedq_edge_cell.sv
hdl/input_edge_queue_core.sv
verif/input_edge_queue_core_tb.sv
